[design/macc_pkg.sv]
package macc_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int MAX_COMPONENTS = 16;
  localparam int DEPTH = MAX_SLOTS * MAX_COMPONENTS;
  localparam int AW = $clog2(DEPTH);

  localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;

  // one-hot sequencer states
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_ACC   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_POST  = 8'b0010_0000,
    S_SQRT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  localparam logic FUNC_ACC = 1'b0;
  localparam logic FUNC_FIN = 1'b1;

  localparam logic [0:0] REG_VLEN = 1'b0;
  localparam logic [0:0] REG_NPATHS = 1'b1;

  // request to the shared divide / root unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] dividend;
    logic [23:0] divisor;
  } dreq_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } dres_t;

endpackage

[design/macc_divroot.sv]
module macc_divroot
  import macc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  dreq_t req,
  output dres_t res
);

  logic [63:0] num;
  logic [63:0] quo;
  logic [64:0] rem;
  logic [23:0] dsr;
  logic        mode;
  logic [5:0]  cnt;
  logic        busy;
  logic        done_q;
  logic [64:0] trial;
  logic [64:0] rem_sh;
  logic [64:0] sub_val;

  // restoring step: divide takes one bit, root takes two bits a step
  always_comb begin
    if (mode) begin
      rem_sh  = {rem[62:0], num[63:62]};
      sub_val = {quo[62:0], 2'b01};
    end else begin
      rem_sh  = {rem[63:0], num[63]};
      sub_val = {41'd0, dsr};
    end
    trial = rem_sh - sub_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.is_sqrt ? 6'd31 : 6'd63;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num  <= req.dividend;
      dsr  <= req.divisor;
      mode <= req.is_sqrt;
      quo  <= '0;
      rem  <= '0;
    end else if (busy) begin
      num <= mode ? {num[61:0], 2'b00} : {num[62:0], 1'b0};
      if (!trial[64]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign res = {done_q, quo};

endmodule

[design/moment_accumulator.sv]
// moment_accumulator: per-entry sum and sum of squares table with finalize.
// input channel in_valid/in_stall carries func, sample_slot, component and
// sample_value; output channel out_valid/out_stall carries mean, variance,
// std_error and saturated, one result per finalize item, none per accumulate.
// an accumulate item is read, updated and written back through the
// single-port store; one to an address past the table is dropped at once.
// a finalize item within the table has its result after three divides
// of 64 iterations and one square root of 32 iterations on the shared
// restoring unit. the block takes one item at a time; in_stall is high
// while it works. after reset a clearing pass writes zero to all 4096
// entries, one a cycle, and the input is stalled until the pass ends;
// configuration writes on the apb port are taken as ever. registers:
// vector_length at 0x0, num_paths at 0x4. a result waits in the output
// register while out_stall is high, and the next item is taken only
// once it has been transferred.
module moment_accumulator
  import macc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [7:0]         sample_slot,
  input  logic [3:0]         component,
  input  logic signed [23:0] sample_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] mean,
  output logic [46:0]        variance,
  output logic [22:0]        std_error,
  output logic               saturated
);

  logic [4:0]  vector_length;
  logic [23:0] num_paths;
  state_t      state;
  logic [AW:0] clr_cnt;
  logic        fn;
  logic        in_range;
  logic [AW-1:0] addr;
  logic [AW-1:0] addr_q;
  logic signed [23:0] val;
  logic [12:0] full_addr;
  logic [1:0]  step;

  logic [47:0] sum_mem [DEPTH];
  logic [63:0] sq_mem  [DEPTH];
  logic        sat_mem [DEPTH];
  logic [47:0] rd_sum;
  logic [63:0] rd_sq;
  logic        rd_sat;
  logic        we;
  logic [47:0] wr_sum;
  logic [63:0] wr_sq;
  logic        wr_sat;

  logic [23:0] npd;
  logic [47:0] smag;
  logic [23:0] mean_r;
  logic [47:0] msq;
  logic [46:0] var_r;
  dreq_t req;
  dres_t res;

  logic        cfg_we;
  logic [23:0] vmag;
  logic [47:0] sq;
  logic signed [48:0] sum_ext;
  logic [64:0] sq_ext;
  logic [23:0] mean_sgn;
  logic [47:0] q_sub;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_NPATHS) ? {8'd0, num_paths} : {27'd0, vector_length};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= 5'd1;
      num_paths     <= 24'd1;
    end else if (cfg_we) begin
      if (paddr[2] == REG_VLEN) vector_length <= pwdata[4:0];
      else num_paths <= pwdata[23:0];
    end
  end

  assign npd = (num_paths == 24'd0) ? 24'd1 : num_paths;
  assign full_addr = ({8'd0, vector_length} * {5'd0, sample_slot}) + {9'd0, component};
  assign in_stall = (state != S_IDLE) || out_valid;

  // store, single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      sum_mem[addr] <= wr_sum;
      sq_mem[addr]  <= wr_sq;
      sat_mem[addr] <= wr_sat;
    end
    rd_sum <= sum_mem[addr];
    rd_sq  <= sq_mem[addr];
    rd_sat <= sat_mem[addr];
  end

  // accumulate update, or zero while clearing
  always_comb begin
    vmag    = val[23] ? 24'(-val) : val;
    sq      = {24'd0, vmag} * {24'd0, vmag};
    sum_ext = $signed({rd_sum[47], rd_sum}) + 49'(val);
    sq_ext  = {1'b0, rd_sq} + {17'd0, sq};
    wr_sat  = rd_sat;
    if (sum_ext[48] != sum_ext[47]) begin
      wr_sum = sum_ext[48] ? SUM_MIN : SUM_MAX;
      wr_sat = 1'b1;
    end else begin
      wr_sum = sum_ext[47:0];
    end
    if (sq_ext[64]) begin
      wr_sq  = '1;
      wr_sat = 1'b1;
    end else begin
      wr_sq = sq_ext[63:0];
    end
    if (state == S_CLEAR) begin
      wr_sum = '0;
      wr_sq  = '0;
      wr_sat = 1'b0;
    end
  end
  assign we = (state == S_CLEAR) || (state == S_ACC);

  assign mean_sgn = rd_sum[47] ? 24'(-mean_r) : mean_r;
  assign q_sub = res.result[47:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      req.start <= 1'b0;
    end else begin
      req.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            fn       <= func;
            val      <= sample_value;
            in_range <= full_addr < 13'(DEPTH);
            if (full_addr < 13'(DEPTH)) state <= S_READ;
            else if (func == FUNC_FIN) state <= S_OUT;
          end
        end
        S_READ: begin
          if (fn == FUNC_ACC) begin
            state <= S_ACC;
          end else begin
            step         <= 2'd0;
            req.start    <= 1'b1;
            req.is_sqrt  <= 1'b0;
            req.divisor  <= npd;
            req.dividend <= {16'd0, rd_sum[47] ? 48'(-rd_sum) : rd_sum};
            state        <= S_DIV;
          end
        end
        S_ACC: state <= S_IDLE;
        S_DIV: begin
          if (res.done) begin
            if (step == 2'd0) begin
              // clamp mean magnitude to the output range
              if (rd_sum[47])
                mean_r <= (res.result > 64'h80_0000) ? 24'h80_0000 : res.result[23:0];
              else
                mean_r <= (res.result > 64'h7F_FFFF) ? 24'h7F_FFFF : res.result[23:0];
              step         <= 2'd1;
              req.start    <= 1'b1;
              req.dividend <= rd_sq;
            end else if (step == 2'd1) begin
              state <= S_POST;
              msq   <= {24'd0, mean_r} * {24'd0, mean_r};
              if (res.result[63:48] != 16'd0) var_r <= '1;
              else var_r <= {47{1'b1}} & 47'(q_sub);
              step  <= 2'd2;
            end else begin
              req.start    <= 1'b1;
              req.is_sqrt  <= 1'b1;
              req.dividend <= res.result;
              state        <= S_SQRT;
            end
          end
        end
        S_POST: begin
          // q minus mean squared, clamped at zero then to 47 bits
          if (var_r == '1 && res.result[63:48] != 16'd0) var_r <= '1;
          else if (res.result > {16'd0, msq}) begin
            if ((res.result - {16'd0, msq}) > 64'h7FFF_FFFF_FFFF) var_r <= '1;
            else var_r <= 47'(res.result - {16'd0, msq});
          end else var_r <= '0;
          state <= S_DIV;
          req.start    <= 1'b1;
          req.dividend <= 64'(res.result > {16'd0, msq} ?
                              (((res.result - {16'd0, msq}) > 64'h7FFF_FFFF_FFFF) ?
                               64'h7FFF_FFFF_FFFF : res.result - {16'd0, msq}) : 64'd0);
        end
        S_SQRT: begin
          if (res.done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign addr = (state == S_CLEAR) ? clr_cnt[AW-1:0] :
                (state == S_IDLE) ? full_addr[AW-1:0] : addr_q;
  always_ff @(posedge clk) begin
    if (state == S_IDLE) addr_q <= full_addr[AW-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_OUT && !out_valid) begin
      if (in_range) begin
        mean      <= mean_sgn;
        variance  <= var_r;
        std_error <= (res.result > 64'h7F_FFFF) ? 23'h7F_FFFF : res.result[22:0];
        saturated <= rd_sat;
      end else begin
        mean      <= '0;
        variance  <= '0;
        std_error <= '0;
        saturated <= 1'b0;
      end
    end
  end

  macc_divroot u_divroot (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall) else $error("accept during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_no_write_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_SQRT) |-> !we) else $error("write during finalize");
`endif

endmodule

[tb/moment_accumulator_tb.sv]
module moment_accumulator_tb;
  import macc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TOTAL_ITEMS = 1450;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic signed [23:0] mean;
    logic [46:0]        variance;
    logic [22:0]        std_error;
    logic               saturated;
  } moments_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = FUNC_ACC;
  logic [7:0]         sample_slot = '0;
  logic [3:0]         component = '0;
  logic signed [23:0] sample_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] mean;
  logic [46:0]        variance;
  logic [22:0]        std_error;
  logic               saturated;

  // mirror of the moment table and the registers
  longint             sum_mirror [DEPTH];
  logic [63:0]        sumsq_mirror [DEPTH];
  logic               sat_mirror [DEPTH];
  logic [4:0]         vlen_q = 5'd1;
  logic [23:0]        npaths_q = 24'd1;

  moments_t           moments_q[$];
  int                 err_cnt = 0;
  int                 items_sent = 0;
  int                 cycles = 0;
  int                 hold_off = 0;
  int                 stall_left = 0;
  bit                 send_quiet = 1'b0;
  bit                 recv_quiet = 1'b0;

  moment_accumulator dut (.*);

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= pick_gap(recv_quiet);
      out_stall <= 1'b0;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root, trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // update the mirror for one transfer, return 1 with moments on a finalize
  function automatic bit predict_moments(logic f, logic [7:0] s, logic [3:0] c,
                                         logic signed [23:0] v, output moments_t m);
    int          addr;
    longint      val, acc, mn;
    logic [63:0] sq, n, smag, mmag, q, var_v, sem;
    addr = int'(vlen_q) * int'(s) + int'(c);
    m = '0;
    if (f == FUNC_ACC) begin
      if (addr >= DEPTH) return 1'b0;
      val = longint'(v);
      sq = 64'(val < 0 ? -val : val);
      sq = sq * sq;
      acc = sum_mirror[addr] + val;
      if (acc > 64'sh7FFF_FFFF_FFFF) begin
        acc = 64'sh7FFF_FFFF_FFFF;
        sat_mirror[addr] = 1'b1;
      end else if (acc < -64'sh8000_0000_0000) begin
        acc = -64'sh8000_0000_0000;
        sat_mirror[addr] = 1'b1;
      end
      sum_mirror[addr] = acc;
      if (sumsq_mirror[addr] > ~64'd0 - sq) begin
        sumsq_mirror[addr] = ~64'd0;
        sat_mirror[addr] = 1'b1;
      end else begin
        sumsq_mirror[addr] = sumsq_mirror[addr] + sq;
      end
      return 1'b0;
    end
    if (addr >= DEPTH) return 1'b1;
    n = (npaths_q == 0) ? 64'd1 : 64'(npaths_q);
    acc = sum_mirror[addr];
    smag = 64'(acc < 0 ? -acc : acc);
    mn = longint'(smag / n);
    if (acc < 0) mn = -mn;
    if (mn > 64'sd8388607) mn = 64'sd8388607;
    if (mn < -64'sd8388608) mn = -64'sd8388608;
    mmag = 64'(mn < 0 ? -mn : mn);
    q = sumsq_mirror[addr] / n;
    var_v = (q > mmag * mmag) ? q - mmag * mmag : 64'd0;
    if (var_v > 64'h7FFF_FFFF_FFFF) var_v = 64'h7FFF_FFFF_FFFF;
    sem = int_sqrt(var_v / n);
    if (sem > 64'h7F_FFFF) sem = 64'h7F_FFFF;
    m.mean = mn[23:0];
    m.variance = var_v[46:0];
    m.std_error = sem[22:0];
    m.saturated = sat_mirror[addr];
    return 1'b1;
  endfunction

  task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %s: expected %0h got %0h at cycle %0d", name, exp_v, act_v, cycles);
  endtask

  // result checker
  always @(posedge clk) begin
    moments_t e;
    if (!rst && out_valid && !out_stall) begin
      if (moments_q.size() == 0) begin
        report_field("unexpected result", 64'd0, 64'd1);
      end else begin
        e = moments_q.pop_front();
        if (mean !== e.mean) report_field("mean", 64'(e.mean), 64'(mean));
        if (variance !== e.variance) report_field("variance", 64'(e.variance), 64'(variance));
        if (std_error !== e.std_error)
          report_field("std_error", 64'(e.std_error), 64'(std_error));
        if (saturated !== e.saturated)
          report_field("saturated", 64'(e.saturated), 64'(saturated));
      end
    end
  end

  // one input transfer
  task automatic send_item(logic f, logic [7:0] s, logic [3:0] c, logic signed [23:0] v);
    int       gap;
    moments_t m;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func <= f;
    sample_slot <= s;
    component <= c;
    sample_value <= v;
    do @(posedge clk); while (in_stall);
    if (predict_moments(f, s, c, v, m)) moments_q.push_back(m);
    items_sent++;
  endtask

  // wait until the block has gone idle
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (moments_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_VLEN) vlen_q = value[4:0];
    else npaths_q = value[23:0];
  endtask

  task automatic set_config(logic [4:0] vl, logic [23:0] np);
    drain();
    write_reg(REG_VLEN, 32'(vl));
    write_reg(REG_NPATHS, 32'(np));
  endtask

  // field extremes, mean and variance clamps, address cases
  task automatic test_directed;
    send_item(FUNC_ACC, 8'd0, 4'd0, 24'sh7FFFFF);
    send_item(FUNC_ACC, 8'd0, 4'd0, 24'sh7FFFFF);
    send_item(FUNC_FIN, 8'd0, 4'd0, 24'sh000000);
    send_item(FUNC_ACC, 8'd1, 4'd0, -24'sh800000);
    send_item(FUNC_ACC, 8'd1, 4'd0, -24'sh800000);
    send_item(FUNC_FIN, 8'd1, 4'd0, 24'shFFFFFF);
    repeat (3) send_item(FUNC_ACC, 8'd2, 4'd5, -24'sh800000);
    send_item(FUNC_FIN, 8'd2, 4'd5, 24'sh0);
    send_item(FUNC_FIN, 8'd77, 4'd9, 24'sh0);
    // address past the table, and the last entry
    set_config(5'd31, 24'd1);
    send_item(FUNC_ACC, 8'd255, 4'd15, 24'sh123456);
    send_item(FUNC_FIN, 8'd255, 4'd15, 24'sh0);
    send_item(FUNC_ACC, 8'd132, 4'd3, 24'sh000100);
    send_item(FUNC_FIN, 8'd132, 4'd3, 24'sh0);
    // zero stride
    set_config(5'd0, 24'd3);
    send_item(FUNC_ACC, 8'd200, 4'd3, -24'sh000321);
    send_item(FUNC_FIN, 8'd9, 4'd3, 24'sh0);
    // component not below the stride
    set_config(5'd4, 24'd0);
    send_item(FUNC_ACC, 8'd1, 4'd9, 24'sh7FFFFF);
    send_item(FUNC_FIN, 8'd3, 4'd1, 24'sh0);
    send_item(FUNC_FIN, 8'd0, 4'd0, 24'sh0);
    set_config(5'd16, 24'hFFFFFF);
    send_item(FUNC_FIN, 8'd0, 4'd0, 24'sh0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure;
    set_config(5'd1, 24'd2);
    send_item(FUNC_FIN, 8'd0, 4'd0, 24'sh0);
    hold_off = 400;
    send_item(FUNC_FIN, 8'd1, 4'd0, 24'sh0);
    for (int i = 0; i < 6; i++) send_item(FUNC_ACC, 8'd5, 4'(i), 24'($urandom));
    send_item(FUNC_FIN, 8'd5, 4'd2, 24'sh0);
  endtask

  // random phases over several settings
  task automatic test_random;
    logic [7:0]         pool_s [8];
    logic [3:0]         pool_c [8];
    logic [4:0]         vl;
    logic [23:0]        np;
    logic signed [23:0] v;
    int                 k, r;
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 5))
        0: vl = 5'd0;
        1: vl = 5'd1;
        2: vl = 5'd16;
        3: vl = 5'd31;
        default: vl = 5'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: np = 24'd0;
        1: np = 24'd1;
        2: np = 24'hFFFFFF;
        3: np = 24'($urandom);
        default: np = 24'($urandom_range(1, 64));
      endcase
      set_config(vl, np);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 8; i++) begin
        pool_s[i] = 8'($urandom_range(0, 255 / (vl == 0 ? 1 : int'(vl)) + 8));
        pool_c[i] = 4'($urandom);
      end
      for (int i = 0; i < 180 && items_sent < TOTAL_ITEMS; i++) begin
        k = $urandom_range(0, 7);
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0: v = 24'($urandom);
          1: v = ($urandom_range(0, 1) == 1) ? 24'sh7FFFFF : -24'sh800000;
          default: v = 24'($signed(12'($urandom)));
        endcase
        if (r < 15)
          send_item(1'($urandom), 8'($urandom), 4'($urandom), 24'($urandom));
        else if (r < 27)
          send_item(FUNC_FIN, pool_s[k], pool_c[k], 24'($urandom));
        else
          send_item(FUNC_ACC, pool_s[k], pool_c[k], v);
      end
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      sum_mirror[i] = 0;
      sumsq_mirror[i] = '0;
      sat_mirror[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && moments_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
design/macc_pkg.sv
design/macc_divroot.sv
design/moment_accumulator.sv
tb/moment_accumulator_tb.sv
